// ----- design/lis_pkg.sv -----
// shared types, sizes and helpers for the longest increasing subsequence block
// no dependencies; imported by lis_core and longest_increasing_subsequence_top

package lis_pkg;

	// store depth and derived widths
	localparam int MAX_LEN = 1024;
	localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int VAL_W   = 32;
	localparam int LEN_W   = 11;

	// sign bit flip makes an unsigned compare order signed values
	localparam logic [VAL_W-1:0] SIGN_FLIP = {1'b1, {(VAL_W-1){1'b0}}};

	// sequencer states of the scan engine
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE,
		ST_FINISH
	} lis_state_t;

	// control from the channel side to the engine
	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] key;
		logic             last;
		logic             slot_free;
	} lis_ctl_t;

	// status from the engine to the channel side
	typedef struct packed {
		logic             busy;
		logic             res_valid;
		logic [LEN_W-1:0] lis_length;
		logic             overflow;
	} lis_sts_t;

	// clamp an internal length to the output field width
	function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] len);
		logic [CNT_W+LEN_W-1:0] wide;
		logic [CNT_W+LEN_W-1:0] lim;
		wide = {{LEN_W{1'b0}}, len};
		lim  = {{CNT_W{1'b0}}, {LEN_W{1'b1}}};
		if (wide > lim) begin
			return {LEN_W{1'b1}};
		end
		return wide[LEN_W-1:0];
	endfunction

endpackage

// ----- design/lis_core.sv -----
// scan engine: element and length stores, one shared compare unit, sequencer
// depends on lis_pkg

module lis_core (
	input  logic              clk,
	input  logic              arst_n,
	input  lis_pkg::lis_ctl_t ctl,
	output lis_pkg::lis_sts_t sts
);
	import lis_pkg::*;

	// stores, no reset: only entries below the count are ever read
	logic [VAL_W-1:0] value_store [MAX_LEN];
	logic [CNT_W-1:0] length_store [MAX_LEN];

	lis_state_t state_q, state_d;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] best_q;
	logic             ovf_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [VAL_W-1:0] key_q;
	logic             last_q;
	logic [CNT_W-1:0] len_q;

	logic             rd_valid_s1;
	logic [VAL_W-1:0] rd_val_s1;
	logic [CNT_W-1:0] rd_len_s1;

	logic             rd_en;
	logic             wr_en;
	logic             scan_end;
	logic             cmp_hit;
	logic [CNT_W-1:0] cand_len;

	assign scan_end = (rd_idx_q == (count_q - CNT_W'(1)));
	assign cand_len = rd_len_s1 + CNT_W'(1);
	assign cmp_hit  = rd_valid_s1 && (rd_val_s1 < key_q) && (cand_len > len_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (ctl.start) begin
					if (count_q == CNT_W'(MAX_LEN)) begin
						state_d = ST_FINISH;
					end else if (count_q == '0) begin
						state_d = ST_WRITE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_WRITE;
			ST_WRITE:  state_d = ST_FINISH;
			ST_FINISH: begin
				if (!last_q || ctl.slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		rd_en          = 1'b0;
		wr_en          = 1'b0;
		sts.busy       = 1'b1;
		sts.res_valid  = 1'b0;
		sts.lis_length = sat_len(best_q);
		sts.overflow   = ovf_q;
		unique case (state_q)
			ST_IDLE:   sts.busy = 1'b0;
			ST_SCAN:   rd_en = 1'b1;
			ST_DRAIN:  ;
			ST_WRITE:  wr_en = 1'b1;
			ST_FINISH: sts.res_valid = last_q && ctl.slot_free;
			default:   ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequence bookkeeping: count, best length, overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			best_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (sts.res_valid) begin
			count_q <= '0;
			best_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (wr_en) begin
			count_q <= count_q + CNT_W'(1);
			if (len_q > best_q) begin
				best_q <= len_q;
			end
		end else if (ctl.start && (state_q == ST_IDLE) && (count_q == CNT_W'(MAX_LEN))) begin
			ovf_q <= 1'b1;
		end
	end

	// read index and read-data valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end else begin
				rd_idx_q <= '0;
			end
		end
	end

	// item capture and running length from the compare unit
	always_ff @(posedge clk) begin
		if (ctl.start && (state_q == ST_IDLE)) begin
			key_q  <= ctl.key;
			last_q <= ctl.last;
			len_q  <= CNT_W'(1);
		end else if (cmp_hit) begin
			len_q <= cand_len;
		end
	end

	// store read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_val_s1 <= value_store[rd_idx_q[ADDR_W-1:0]];
			rd_len_s1 <= length_store[rd_idx_q[ADDR_W-1:0]];
		end
	end

	// store write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			value_store[count_q[ADDR_W-1:0]]  <= key_q;
			length_store[count_q[ADDR_W-1:0]] <= len_q;
		end
	end

	// read data only returns while scanning or draining
	a_rd_window: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("read data outside scan window");

	// count never passes the store depth
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_LEN))
		else $error("element count beyond store depth");

	// best length never exceeds the kept element count
	a_best_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		best_q <= count_q)
		else $error("best length above element count");

	// a result is offered only when the output slot can take it
	a_res_slot: assert property (@(posedge clk) disable iff (!arst_n)
		sts.res_valid |-> ctl.slot_free)
		else $error("result with no free output slot");

	// a delivered result clears the sequence
	a_res_clear: assert property (@(posedge clk) disable iff (!arst_n)
		sts.res_valid |=> (count_q == '0 && best_q == '0 && !ovf_q))
		else $error("sequence not cleared after result");

endmodule

// ----- design/longest_increasing_subsequence_top.sv -----
// top level: input and output channels around the scan engine
// depends on lis_pkg and lis_core
//
// Usage: send a sequence of signed 32-bit values on the input channel
// (in_valid, in_stall, value_in, last), one value per item, with last set
// on the final one. An item is taken at a clock edge with in_valid high and
// in_stall low. Each item is compared against every element already kept
// for the sequence, one stored element per cycle through a single compare
// unit fed by the store read port, then passes the drain, write-back and
// finish states before the next item is taken. A sequence's first item
// skips the scan; an item dropped because the store is full also skips
// the write-back. Up to MAX_LEN (1024) elements are kept. On the last
// item one result (lis_length, overflow) is loaded into the output
// register from the finish state once the register is free; out_valid
// holds it until out_stall is low. While a result waits, further items
// are still taken; only a following last item waits for the register to
// free up. Reset clears the sequence count, best length, overflow flag and
// output valid; the stores need no clearing pass and are ready at once.

module longest_increasing_subsequence_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] value_in,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic        [10:0] lis_length,
	output logic               overflow
);
	import lis_pkg::*;

	lis_ctl_t ctl;
	lis_sts_t sts;

	logic             out_valid_q;
	logic [LEN_W-1:0] lis_length_q;
	logic             overflow_q;

	// input side: engine takes an item only while idle
	assign in_stall      = sts.busy;
	assign ctl.start     = in_valid && !sts.busy;
	assign ctl.key       = VAL_W'(value_in) ^ SIGN_FLIP;
	assign ctl.last      = last;
	assign ctl.slot_free = !out_valid_q || !out_stall;

	lis_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sts.res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (sts.res_valid) begin
			lis_length_q <= sts.lis_length;
			overflow_q   <= sts.overflow;
		end
	end

	assign out_valid  = out_valid_q;
	assign lis_length = lis_length_q;
	assign overflow   = overflow_q;

endmodule

// ----- tb/longest_increasing_subsequence_top_tb.sv -----
// testbench for the longest increasing subsequence block: directed, random and store-full tests
// depends on lis_pkg and longest_increasing_subsequence_top; self-checking, needs no files

module longest_increasing_subsequence_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH   = lis_pkg::MAX_LEN;
	localparam int LEN_W   = lis_pkg::LEN_W;
	localparam int LEN_MAX = (1 << LEN_W) - 1;
	localparam int RANDOM_ITEMS = 500;

	// shapes of the value streams in random sequences
	typedef enum int {
		FILL_WIDE,
		FILL_NARROW,
		FILL_RISING,
		FILL_EXTREME
	} fill_mode_t;

	typedef struct {
		logic [LEN_W-1:0] len;
		logic             ovf;
	} lis_answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] value_in = '0;
	logic               last = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [10:0]        lis_length;
	logic               overflow;

	// shared run state
	bit          calm = 1'b0;
	int          stall_left = 0;
	int          errors = 0;
	int          items_sent = 0;
	int          answers_seen = 0;
	int          overflow_seqs = 0;
	lis_answer_t pending_answers[$];

	// predictor copy of the sequence state
	logic signed [31:0] kept_vals [DEPTH];
	int                 kept_lens [DEPTH];
	int                 kept_count = 0;
	int                 best_len = 0;
	bit                 dropped = 1'b0;

	longest_increasing_subsequence_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value_in   (value_in),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.lis_length (lis_length),
		.overflow   (overflow)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// hard limit on run time
	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	// add one element to the predicted sequence, queue the answer on the last one
	task automatic extend_subsequence(input logic signed [31:0] v, input logic l);
		int          run_len;
		lis_answer_t ans;
		if (kept_count < DEPTH) begin
			run_len = 1;
			for (int j = 0; j < kept_count; j++) begin
				if (kept_vals[j] < v && kept_lens[j] + 1 > run_len) begin
					run_len = kept_lens[j] + 1;
				end
			end
			kept_vals[kept_count] = v;
			kept_lens[kept_count] = run_len;
			kept_count++;
			if (run_len > best_len) begin
				best_len = run_len;
			end
		end else begin
			dropped = 1'b1;
		end
		if (l) begin
			ans.len = (best_len > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(best_len);
			ans.ovf = dropped;
			pending_answers = {pending_answers, ans};
			if (dropped) begin
				overflow_seqs++;
			end
			kept_count = 0;
			best_len = 0;
			dropped = 1'b0;
		end
	endtask

	// idle length before an item: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [31:0] pick_value(input fill_mode_t mode, input int base,
			input int idx);
		case (mode)
			FILL_WIDE: begin
				return $urandom;
			end
			FILL_NARROW: begin
				return int'($urandom_range(0, 6)) - 3;
			end
			FILL_RISING: begin
				return base + idx * 8 + int'($urandom_range(0, 15)) - 8;
			end
			default: begin
				case ($urandom_range(0, 4))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return -32'sd1;
					3: return 32'sd0;
					default: return 32'sd1;
				endcase
			end
		endcase
	endfunction

	// send one item; called and returning at a rising edge
	task automatic send_item(input logic signed [31:0] v, input logic l);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value_in <= v;
		last <= l;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		extend_subsequence(v, l);
		items_sent++;
	endtask

	task automatic send_sequence(input logic signed [31:0] vals[$]);
		for (int i = 0; i < vals.size(); i++) begin
			send_item(vals[i], i == vals.size() - 1);
		end
	endtask

	// result side back-pressure, with calm stretches
	always @(posedge clk) begin : stall_gen
		int r;
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (calm) begin
			out_stall <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				out_stall <= 1'b0;
				stall_left <= $urandom_range(0, 6);
			end else if (r < 92) begin
				out_stall <= 1'b1;
				stall_left <= $urandom_range(0, 3);
			end else begin
				out_stall <= 1'b1;
				stall_left <= $urandom_range(10, 50);
			end
		end
	end

	// compare each accepted result with the oldest predicted answer
	always @(negedge clk) begin : answer_check
		lis_answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected result lis_length %0d overflow %0d",
					$time, lis_length, overflow);
				errors++;
			end else begin
				want = pending_answers.pop_front();
				answers_seen++;
				if (lis_length !== want.len) begin
					$display("%0t: lis_length expected %0d got %0d", $time, want.len, lis_length);
					errors++;
				end
				if (overflow !== want.ovf) begin
					$display("%0t: overflow expected %0d got %0d", $time, want.ovf, overflow);
					errors++;
				end
			end
		end
	end

	// single elements at both ends, full-range rise, fall, equal values, a mix
	task automatic test_directed_sequences();
		logic signed [31:0] seq[$];
		seq = '{32'sh8000_0000};
		send_sequence(seq);
		seq = '{32'sh7fff_ffff};
		send_sequence(seq);
		seq = '{32'sh8000_0000, -32'sd1, 32'sd0, 32'sd1, 32'sh7fff_ffff};
		send_sequence(seq);
		seq = '{32'sh7fff_ffff, 32'sd0, 32'sh8000_0000};
		send_sequence(seq);
		seq = '{32'sd7, 32'sd7, 32'sd7};
		send_sequence(seq);
		seq = '{32'sd3, 32'sd1, 32'sd2, 32'sd2, 32'sd5, 32'sd4};
		send_sequence(seq);
	endtask

	// fill the store, drop two more items (the last one carries the mark), then recover
	task automatic test_store_full();
		logic signed [31:0] seq[$];
		calm = 1'b1;
		for (int i = 0; i < DEPTH; i++) begin
			send_item(pick_value(FILL_RISING, -4096, i), 1'b0);
		end
		send_item(32'sh7fff_ffff, 1'b0);
		send_item(32'sh8000_0000, 1'b1);
		calm = 1'b0;
		seq = '{32'sd1, 32'sd2};
		send_sequence(seq);
	endtask

	// well-formed sequences of random length and content
	task automatic test_random_sequences();
		int         sent;
		int         seq_len;
		int         r;
		int         base;
		fill_mode_t mode;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				seq_len = $urandom_range(1, 6);
			end else if (r < 85) begin
				seq_len = $urandom_range(7, 24);
			end else if (r < 97) begin
				seq_len = $urandom_range(25, 80);
			end else begin
				seq_len = $urandom_range(150, 300);
			end
			mode = fill_mode_t'($urandom_range(0, 3));
			base = int'($urandom_range(0, 2000)) - 1000;
			calm = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < seq_len; i++) begin
				send_item(pick_value(mode, base, i), i == seq_len - 1);
			end
			sent += seq_len;
		end
		calm = 1'b0;
	endtask

	// reset, tests in turn, drain, verdict
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_sequences();
		test_random_sequences();
		test_store_full();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (1100) @(posedge clk);
		$display("covered %0d items, %0d results checked, %0d sequences past the store depth",
			items_sent, answers_seen, overflow_seqs);
		$display("mismatches: %0d", errors);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/lis_pkg.sv
design/lis_core.sv
design/longest_increasing_subsequence_top.sv
tb/longest_increasing_subsequence_top_tb.sv
